### src/bir_pkg.sv
// Shared types, constants and command structures for the bicubic resize block.
package bir_pkg;

   localparam int MAX_SRC_DIM = 256;
   localparam int MAX_DST_DIM = 4096;
   localparam int PIXEL_BITS  = 8;

   localparam int SRC_REG_W = 9;
   localparam int DST_REG_W = 13;
   localparam int CSR_DATA_W = 13;
   localparam int ADDR_W = 16;
   localparam int COORD_W = 12;
   localparam int DIM_W = 9;       // effective source dimension, 1..256
   localparam int DDIM_W = 13;     // effective destination dimension, 1..4096
   localparam int DIVISOR_W = 14;  // twice the destination dimension
   localparam int NUMER_W = 37;    // (2o + 1) * src in Q.16
   localparam int POS_W = 24;      // clamped source position in Q.16
   localparam int FRAC_W = 16;
   localparam int IDX_W = 8;
   localparam int DIST_W = 18;     // kernel distance in Q.16, up to 2.0
   localparam int WGT_W = 16;      // signed Q2.14 weight
   localparam int WPROD_W = 32;
   localparam int TERM_W = 41;
   localparam int ACC_W = 46;
   localparam int CNT_W = 5;

   localparam logic [CNT_W-1:0] WGT_LAST = 5'd12;
   localparam logic [CNT_W-1:0] WGT_ISSUE_LAST = 5'd7;
   localparam logic [CNT_W-1:0] TAP_LAST = 5'd17;
   localparam logic [CNT_W-1:0] TAP_ISSUE_LAST = 5'd15;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD    = 1'b0,
      FUNC_COMPUTE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVX_GO,
      ST_DIVX_RUN,
      ST_DIVY_GO,
      ST_DIVY_RUN,
      ST_WGT,
      ST_TAP,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       load_en;
      logic       capture;
      logic       div_start;
      logic       div_sel_y;
      logic       acc_clr;
      logic       wgt_valid;
      logic [2:0] wgt_idx;
      logic       tap_valid;
      logic [3:0] tap_idx;
      logic       res_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

### src/bir_div.sv
// Radix-2 restoring divider for the source position, one quotient bit per cycle.
module bir_div
   import bir_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUMER_W-1:0]   numer,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [NUMER_W-1:0]   quot,
   output logic                 done
);

   localparam logic [5:0] STEPS = 6'(NUMER_W);

   logic [NUMER_W-1:0]   n_ff, n_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] d_ff, d_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   rem_sh;
   logic                 ge;

   // Load on start, else one shift-subtract step
   always_comb begin
      rem_sh = {rem_ff, n_ff[NUMER_W-1]};
      ge = rem_sh >= {1'b0, d_ff};
      n_in = n_ff;
      rem_in = rem_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         n_in = numer;
         rem_in = '0;
         d_in = divisor;
         cnt_in = STEPS;
      end else if (cnt_ff != 6'd0) begin
         rem_in = ge ? DIVISOR_W'(rem_sh - {1'b0, d_ff}) : DIVISOR_W'(rem_sh);
         n_in = {n_ff[NUMER_W-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      rem_ff <= rem_in;
      d_ff <= d_in;
   end

   assign quot = n_ff;
   assign done = done_ff;

endmodule

### src/bir_kernel.sv
// Six-stage pipeline that turns a Q.16 distance into a Mitchell-Netravali Q2.14 weight.
module bir_kernel
   import bir_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [DIST_W-1:0]        in_dist,
   input  logic [2:0]               in_tag,
   output logic                     out_valid,
   output logic signed [WGT_W-1:0]  out_wgt,
   output logic [2:0]               out_tag
);

   localparam int NUM_W = 59;
   localparam int V_W = 20;
   localparam logic signed [NUM_W-1:0] K_NEAR = NUM_W'(64'sd1 <<< 52);
   localparam logic signed [NUM_W-1:0] K_FAR = NUM_W'(64'sd1 <<< 53);
   localparam logic [NUM_W-1:0] K_HALF = NUM_W'(64'd9 << 34);
   localparam logic [15:0] RECIP18 = 16'd58255;

   logic [5:0]  vld_ff;
   logic [2:0]  tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff;
   // stage 1
   logic [16:0] u1_ff;
   logic [33:0] u2_1_ff;
   logic        near1_ff, zero1_ff;
   // stage 2
   logic [16:0] u_2_ff;
   logic [50:0] u3_2_ff;
   logic [39:0] t36_2_ff;
   logic        near2_ff, zero2_ff;
   // stage 3
   logic signed [NUM_W-1:0] num_ff, num_in;
   // stage 4
   logic [V_W-1:0] v4_ff, v4_in;
   logic           neg4_ff, neg5_ff;
   logic [NUM_W-1:0] mag;
   // stage 5
   logic [V_W-1:0] v5_ff;
   logic [15:0]    q0_ff;
   logic [35:0]    q0_full;
   // stage 6
   logic signed [WGT_W-1:0] w_ff, w_in;
   logic [15:0] q;
   logic [V_W:0] q0x18;

   logic signed [NUM_W-1:0] a_u3, a_t36, a_u;

   // Polynomial numerator for either branch
   always_comb begin
      a_u3 = $signed({8'd0, u3_2_ff});
      a_t36 = $signed({3'd0, t36_2_ff, 16'd0});
      a_u = $signed({10'd0, u_2_ff, 32'd0});
      if (zero2_ff) begin
         num_in = '0;
      end else if (near2_ff) begin
         num_in = a_u3 * NUM_W'(21) - a_t36 + K_NEAR;
      end else begin
         num_in = a_t36 - a_u3 * NUM_W'(7) - a_u * NUM_W'(60) + K_FAR;
      end
   end

   // Add half the divisor to the magnitude and truncate to the 2^34 grid
   always_comb begin
      mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
      v4_in = V_W'((mag + K_HALF) >> 34);
   end

   assign q0_full = {16'd0, v4_ff} * {20'd0, RECIP18};

   // Correct the reciprocal estimate and apply sign
   always_comb begin
      q0x18 = (V_W+1)'({q0_ff, 4'd0}) + (V_W+1)'({q0_ff, 1'b0});
      q = (q0x18 > {1'b0, v5_ff}) ? q0_ff - 16'd1 : q0_ff;
      w_in = neg5_ff ? -$signed(q) : $signed(q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
      u1_ff <= in_dist[16:0];
      u2_1_ff <= in_dist[16:0] * in_dist[16:0];
      near1_ff <= (in_dist[17:16] == 2'd0);
      zero1_ff <= in_dist[17];
      tag1_ff <= in_tag;
      u_2_ff <= u1_ff;
      u3_2_ff <= 51'(u2_1_ff) * 51'(u1_ff);
      t36_2_ff <= 40'(u2_1_ff) * 40'd36;
      near2_ff <= near1_ff;
      zero2_ff <= zero1_ff;
      tag2_ff <= tag1_ff;
      num_ff <= num_in;
      tag3_ff <= tag2_ff;
      v4_ff <= v4_in;
      neg4_ff <= num_ff[NUM_W-1];
      tag4_ff <= tag3_ff;
      q0_ff <= q0_full[35:20];
      v5_ff <= v4_ff;
      neg5_ff <= neg4_ff;
      tag5_ff <= tag4_ff;
      w_ff <= w_in;
      tag6_ff <= tag5_ff;
   end

   assign out_valid = vld_ff[5];
   assign out_wgt = w_ff;
   assign out_tag = tag6_ff;

endmodule

### src/bir_datapath.sv
// Datapath: settings, source memory, position division, weights and the 4x4 sum.
module bir_datapath
   import bir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [47:0]           req_tdata,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tuser
);

   logic [SRC_REG_W-1:0] src_w_ff, src_h_ff;
   logic [DST_REG_W-1:0] dst_w_ff, dst_h_ff;
   logic [DIM_W-1:0]     sw, sh, sdim;
   logic [DDIM_W-1:0]    dw, dh, ddim;

   logic [COORD_W-1:0]   ox_ff, oy_ff, o_sel;
   logic [NUMER_W-1:0]   numer, quot;
   logic [20:0]          prod_os;

   logic [IDX_W-1:0]     bx_ff, by_ff;
   logic [FRAC_W-1:0]    fx_ff, fy_ff, f_sel;
   logic [NUMER_W-1:0]   p_raw;
   logic [POS_W-1:0]     hi_pos, pos;

   logic [DIST_W-1:0]    k_dist;
   logic                 k_valid;
   logic signed [WGT_W-1:0] k_wgt;
   logic [2:0]           k_tag;
   logic signed [WGT_W-1:0] wx_ff [4];
   logic signed [WGT_W-1:0] wy_ff [4];

   logic [PIXEL_BITS-1:0] mem [MAX_SRC_DIM*MAX_SRC_DIM];
   logic [PIXEL_BITS-1:0] rdata_ff;
   logic signed [10:0]   row_s, col_s;
   logic [IDX_W-1:0]     row, col;
   logic [ADDR_W-1:0]    tap_addr;
   logic [16:0]          row_base;
   logic signed [WPROD_W-1:0] wprod_ff;
   logic signed [TERM_W-1:0]  term_ff;
   logic                 s1_ff, s2_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] adj;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SRC_REG_W'(MAX_SRC_DIM);
         src_h_ff <= SRC_REG_W'(MAX_SRC_DIM);
         dst_w_ff <= DST_REG_W'(256);
         dst_h_ff <= DST_REG_W'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[SRC_REG_W-1:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[SRC_REG_W-1:0];
            CSR_DST_WIDTH:  dst_w_ff <= csr_wdata;
            CSR_DST_HEIGHT: dst_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective dimensions: zero reads as one, oversize clamps
   always_comb begin
      sw = (src_w_ff == '0) ? DIM_W'(1) :
           (src_w_ff > SRC_REG_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_w_ff;
      sh = (src_h_ff == '0) ? DIM_W'(1) :
           (src_h_ff > SRC_REG_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_h_ff;
      dw = (dst_w_ff == '0) ? DDIM_W'(1) :
           (dst_w_ff > DST_REG_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_w_ff;
      dh = (dst_h_ff == '0) ? DDIM_W'(1) :
           (dst_h_ff > DST_REG_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_h_ff;
      sdim = cmd.div_sel_y ? sh : sw;
      ddim = cmd.div_sel_y ? dh : dw;
      o_sel = cmd.div_sel_y ? oy_ff : ox_ff;
   end

   // Hold the destination coordinates of the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ox_ff <= req_tdata[35:24];
         oy_ff <= req_tdata[47:36];
      end
   end

   // Position numerator (2o + 1) * src in Q.16
   assign prod_os = 21'({o_sel, 1'b1}) * 21'(sdim);
   assign numer = {prod_os, 16'd0};

   bir_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .numer   (numer),
      .divisor ({ddim, 1'b0}),
      .quot    (quot),
      .done    (status.div_done)
   );

   // Remove the half-pixel offset and clamp to the image
   always_comb begin
      hi_pos = {sdim[IDX_W-1:0] - IDX_W'(1), 16'd0};
      p_raw = quot - NUMER_W'(32768);
      if (quot < NUMER_W'(32768)) begin
         pos = '0;
      end else if (p_raw > NUMER_W'(hi_pos)) begin
         pos = hi_pos;
      end else begin
         pos = p_raw[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (status.div_done) begin
         if (cmd.div_sel_y) begin
            by_ff <= pos[POS_W-1:FRAC_W];
            fy_ff <= pos[FRAC_W-1:0];
         end else begin
            bx_ff <= pos[POS_W-1:FRAC_W];
            fx_ff <= pos[FRAC_W-1:0];
         end
      end
   end

   // Kernel distances 1+f, f, 1-f, 2-f
   always_comb begin
      f_sel = cmd.wgt_idx[2] ? fy_ff : fx_ff;
      unique case (cmd.wgt_idx[1:0])
         2'd0: k_dist = DIST_W'(65536) + DIST_W'(f_sel);
         2'd1: k_dist = DIST_W'(f_sel);
         2'd2: k_dist = DIST_W'(65536) - DIST_W'(f_sel);
         default: k_dist = DIST_W'(131072) - DIST_W'(f_sel);
      endcase
   end

   bir_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.wgt_valid),
      .in_dist   (k_dist),
      .in_tag    (cmd.wgt_idx),
      .out_valid (k_valid),
      .out_wgt   (k_wgt),
      .out_tag   (k_tag)
   );

   // Store weights as they leave the kernel pipeline
   always_ff @(posedge clock) begin
      if (k_valid) begin
         if (k_tag[2]) begin
            wy_ff[k_tag[1:0]] <= k_wgt;
         end else begin
            wx_ff[k_tag[1:0]] <= k_wgt;
         end
      end
   end

   // Edge-clamped neighbor address
   always_comb begin
      row_s = $signed({3'd0, by_ff}) - 11'sd1 + $signed({9'd0, cmd.tap_idx[3:2]});
      col_s = $signed({3'd0, bx_ff}) - 11'sd1 + $signed({9'd0, cmd.tap_idx[1:0]});
      if (row_s < 11'sd0) begin
         row = '0;
      end else if (row_s > $signed({2'd0, sh}) - 11'sd1) begin
         row = sh[IDX_W-1:0] - IDX_W'(1);
      end else begin
         row = row_s[IDX_W-1:0];
      end
      if (col_s < 11'sd0) begin
         col = '0;
      end else if (col_s > $signed({2'd0, sw}) - 11'sd1) begin
         col = sw[IDX_W-1:0] - IDX_W'(1);
      end else begin
         col = col_s[IDX_W-1:0];
      end
      row_base = 17'(row) * 17'(sw);
      tap_addr = ADDR_W'(row_base + 17'(col));
   end

   // Source memory: write on load, registered read on tap
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         mem[req_tdata[15:0]] <= req_tdata[23:16];
      end
      if (cmd.tap_valid) begin
         rdata_ff <= mem[tap_addr];
      end
   end

   // Weight product, pixel term, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.tap_valid;
         s2_ff <= s1_ff;
      end
      wprod_ff <= WPROD_W'(wy_ff[cmd.tap_idx[3:2]]) * WPROD_W'(wx_ff[cmd.tap_idx[1:0]]);
      term_ff <= TERM_W'($signed({1'b0, rdata_ff})) * TERM_W'(wprod_ff);
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (s2_ff) begin
         acc_ff <= acc_ff + ACC_W'(term_ff);
      end
   end

   // Round, saturate and hold the result
   assign adj = acc_ff + ACC_W'(64'sd1 <<< 27);

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         if (adj < 0) begin
            rsp_tdata <= '0;
            rsp_tuser <= 1'b1;
         end else if ((adj >>> 28) > ACC_W'(255)) begin
            rsp_tdata <= 8'd255;
            rsp_tuser <= 1'b1;
         end else begin
            rsp_tdata <= adj[35:28];
            rsp_tuser <= 1'b0;
         end
      end
   end

endmodule

### src/bir_ctrl.sv
// Controller state machine: request handshake, sequencing and result valid.
module bir_ctrl
   import bir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state and step count
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && func_type'(req_tuser) == FUNC_COMPUTE) begin
               state_in = ST_DIVX_GO;
            end
         end
         ST_DIVX_GO: state_in = ST_DIVX_RUN;
         ST_DIVX_RUN: begin
            if (status.div_done) state_in = ST_DIVY_GO;
         end
         ST_DIVY_GO: state_in = ST_DIVY_RUN;
         ST_DIVY_RUN: begin
            if (status.div_done) begin
               state_in = ST_WGT;
               cnt_in = '0;
            end
         end
         ST_WGT: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == WGT_LAST) begin
               state_in = ST_TAP;
               cnt_in = '0;
            end
         end
         ST_TAP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == TAP_LAST) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load_en = req_tvalid && func_type'(req_tuser) == FUNC_LOAD;
            cmd.capture = req_tvalid && func_type'(req_tuser) == FUNC_COMPUTE;
         end
         ST_DIVX_GO: begin
            cmd.div_start = 1'b1;
            cmd.acc_clr = 1'b1;
         end
         ST_DIVX_RUN: ;
         ST_DIVY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel_y = 1'b1;
         end
         ST_DIVY_RUN: cmd.div_sel_y = 1'b1;
         ST_WGT: begin
            cmd.wgt_valid = (cnt_ff <= WGT_ISSUE_LAST);
            cmd.wgt_idx = cnt_ff[2:0];
         end
         ST_TAP: begin
            cmd.tap_valid = (cnt_ff <= TAP_ISSUE_LAST);
            cmd.tap_idx = cnt_ff[3:0];
         end
         ST_FIN: cmd.res_load = out_free;
         default: ;
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### src/bicubic_image_resize.sv
// A load request is written when accepted; loads are accepted back to back.
// A compute request has its result valid after bit-serial position division per
// axis, the weight pipeline, neighbor reads from the source memory and rounding.
// A compute request closes the input until its result is loaded; one result may
// wait at the output.
// Reset is synchronous: control and size settings reset; the source memory does not.
module bicubic_image_resize
   import bir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: load_addr[15:0], pixel_in[23:16], out_x[35:24], out_y[47:36]
   input  logic [47:0]           req_tdata,
   // tuser: func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: pixel_out[7:0]
   output logic [7:0]            rsp_tdata,
   // tuser: saturated
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bir_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Accepting a compute request closes the input
   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("request accepted while a compute is running");

   // A result is never loaded over one not yet taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten");

   // Memory reads never mix with accepting requests or with memory writes
   a_tap_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.tap_valid |-> !req_tready && !cmd.load_en)
      else $error("neighbor read while idle");

endmodule

### sim/testbench.sv
// Testbench for the bicubic resize block: predicts each interpolated pixel and checks every result.
module testbench
   import bir_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int ITEM_TARGET    = 1150;

   typedef struct {
      logic [7:0] pixel;
      logic       sat;
   } pixel_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow state of the block
   logic [7:0]       image_mem [0:65535];
   int unsigned      image_fill;
   logic [12:0]      cfg_reg [0:3];
   pixel_result_type pixel_queue [$];

   int  error_count;
   int  items_sent;
   int  load_count;
   int  compute_count;
   int  sat_count;
   int  idle_cycles;
   int  long_hold_req;
   bit  tx_idle_en;
   bit  rx_idle_en;

   bicubic_image_resize dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mitchell-Netravali weight for distance u in Q.16, rounded to Q2.14
   function automatic longint kernel_weight(input longint u);
      longint num, mag, q;
      longint den;
      den = 18 * (longint'(1) <<< 34);
      if (u < 65536)
         num = 21 * u * u * u - 36 * u * u * 65536 + 16 * (longint'(1) <<< 48);
      else if (u < 131072)
         num = -7 * u * u * u + 36 * u * u * 65536 - 60 * u * (longint'(1) <<< 32)
               + 32 * (longint'(1) <<< 48);
      else
         return 0;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint eff_dim(input longint v, input longint maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   // half-pixel-centered source position, clamped to the image
   function automatic longint src_position(input longint o, input longint sdim,
                                            input longint ddim);
      longint p;
      p = (((2 * o + 1) * sdim) <<< 16) / (2 * ddim) - 32768;
      if (p < 0) p = 0;
      if (p > (sdim - 1) * 65536) p = (sdim - 1) * 65536;
      return p;
   endfunction

   function automatic void axis_weights(input longint pos, output longint w[4],
                                        output longint base);
      longint f;
      f = pos % 65536;
      base = pos / 65536;
      w[0] = kernel_weight(65536 + f);
      w[1] = kernel_weight(f);
      w[2] = kernel_weight(65536 - f);
      w[3] = kernel_weight(131072 - f);
   endfunction

   function automatic pixel_result_type interpolate_pixel(input logic [11:0] ox,
                                                           input logic [11:0] oy);
      pixel_result_type res;
      longint sw, sh, dw, dh, bx, by, row, col, sum, adj;
      longint wx[4], wy[4];
      sw = eff_dim(cfg_reg[CSR_SRC_WIDTH], MAX_SRC_DIM);
      sh = eff_dim(cfg_reg[CSR_SRC_HEIGHT], MAX_SRC_DIM);
      dw = eff_dim(cfg_reg[CSR_DST_WIDTH], MAX_DST_DIM);
      dh = eff_dim(cfg_reg[CSR_DST_HEIGHT], MAX_DST_DIM);
      axis_weights(src_position(ox, sw, dw), wx, bx);
      axis_weights(src_position(oy, sh, dh), wy, by);
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         row = by - 1 + i;
         if (row < 0) row = 0;
         if (row > sh - 1) row = sh - 1;
         for (int j = 0; j < 4; j++) begin
            col = bx - 1 + j;
            if (col < 0) col = 0;
            if (col > sw - 1) col = sw - 1;
            sum += longint'(image_mem[row * sw + col]) * wy[i] * wx[j];
         end
      end
      adj = sum + (longint'(1) <<< 27);
      res.sat = 1'b0;
      if (adj < 0) begin
         res.pixel = 8'd0;
         res.sat = 1'b1;
      end else if ((adj >>> 28) > 255) begin
         res.pixel = 8'hFF;
         res.sat = 1'b1;
      end else begin
         res.pixel = 8'(adj >>> 28);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
      error_count++;
   endtask

   // send one request; predict on acceptance
   task automatic send_request(input func_type func, input logic [15:0] addr,
                               input logic [7:0] pix, input logic [11:0] ox,
                               input logic [11:0] oy);
      @(negedge clock);
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {oy, ox, pix, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (func == FUNC_LOAD) begin
         image_mem[addr] = pix;
         load_count++;
      end else begin
         pixel_queue.push_back(interpolate_pixel(ox, oy));
         compute_count++;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [12:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_reg[idx] = (idx == CSR_SRC_WIDTH || idx == CSR_SRC_HEIGHT) ?
                     (value & 13'h1FF) : value;
   endtask

   function automatic logic [7:0] random_pixel();
      // many hard edges so that overshoot saturates
      if ($urandom_range(0, 1)) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   // reconfigure while idle, then fill any source entries not yet written
   task automatic set_sizes(input logic [12:0] sw, input logic [12:0] sh,
                            input logic [12:0] dw, input logic [12:0] dh);
      int unsigned need;
      wait_idle();
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      write_csr(CSR_DST_WIDTH, dw);
      write_csr(CSR_DST_HEIGHT, dh);
      need = eff_dim(cfg_reg[CSR_SRC_WIDTH], MAX_SRC_DIM) *
             eff_dim(cfg_reg[CSR_SRC_HEIGHT], MAX_SRC_DIM);
      while (image_fill < need) begin
         send_request(FUNC_LOAD, 16'(image_fill), random_pixel(), 12'($urandom),
                      12'($urandom));
         image_fill++;
      end
   endtask

   // mostly in-range destinations, sometimes anywhere in the field
   task automatic send_compute();
      logic [11:0] ox, oy;
      longint dw, dh;
      dw = eff_dim(cfg_reg[CSR_DST_WIDTH], MAX_DST_DIM);
      dh = eff_dim(cfg_reg[CSR_DST_HEIGHT], MAX_DST_DIM);
      ox = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, dw - 1));
      oy = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, dh - 1));
      send_request(FUNC_COMPUTE, 16'($urandom), 8'($urandom), ox, oy);
   endtask

   // rewrite a pixel of the current image, or anywhere in memory
   task automatic send_reload();
      int unsigned n;
      logic [15:0] addr;
      n = eff_dim(cfg_reg[CSR_SRC_WIDTH], MAX_SRC_DIM) *
          eff_dim(cfg_reg[CSR_SRC_HEIGHT], MAX_SRC_DIM);
      addr = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, n - 1));
      send_request(FUNC_LOAD, addr, random_pixel(), 12'($urandom), 12'($urandom));
   endtask

   task automatic test_directed();
      set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
      send_request(FUNC_COMPUTE, 16'h0, 8'h0, 12'd0, 12'd0);
      send_request(FUNC_COMPUTE, 16'h0, 8'h0, 12'hFFF, 12'hFFF);
      send_request(FUNC_LOAD, 16'hFFFF, 8'hAA, 12'hFFF, 12'hFFF);
      send_request(FUNC_LOAD, 16'h8000, 8'h55, 12'h0, 12'h0);
      send_request(FUNC_LOAD, 16'h0, 8'hFF, 12'h0, 12'h0);
      send_request(FUNC_COMPUTE, 16'hFFFF, 8'hFF, 12'd0, 12'd0);
      // checkerboard of hard edges, upscaled
      set_sizes(13'd4, 13'd4, 13'd4096, 13'd13);
      for (int a = 0; a < 16; a++)
         send_request(FUNC_LOAD, 16'(a), ((a + a / 4) % 2) ? 8'hFF : 8'h00, 12'd0, 12'd0);
      send_request(FUNC_COMPUTE, 16'h0, 8'h0, 12'd0, 12'd0);
      send_request(FUNC_COMPUTE, 16'h0, 8'h0, 12'd1500, 12'd5);
      send_request(FUNC_COMPUTE, 16'h0, 8'h0, 12'd4095, 12'd12);
      send_request(FUNC_COMPUTE, 16'h0, 8'h0, 12'd4095, 12'd4095);
   endtask

   // largest, smallest, zero and oversized dimensions
   task automatic test_extreme_sizes();
      set_sizes(13'd256, 13'd1, 13'd13, 13'd4096);
      repeat (15) send_compute();
      set_sizes(13'd1, 13'd256, 13'd4096, 13'd7);
      repeat (15) send_compute();
      set_sizes(13'd0, 13'd511, 13'd8191, 13'd0);
      repeat (15) send_compute();
      set_sizes(13'd16, 13'd16, 13'd1, 13'd4096);
      repeat (15) send_compute();
   endtask

   // receiver holds off long enough that the block stalls its input,
   // then the sender pauses until every result is back
   task automatic test_backpressure();
      set_sizes(13'd7, 13'd5, 13'd19, 13'd11);
      @(negedge clock);
      long_hold_req = 600;
      repeat (8) send_compute();
      wait_idle();
      repeat (6) send_compute();
   endtask

   task automatic test_random_phases(input int stop_at);
      int n;
      while (items_sent < stop_at) begin
         set_sizes(13'($urandom_range(1, 12)), 13'($urandom_range(1, 12)),
                   ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096)) :
                                                 13'($urandom_range(1, 40)),
                   ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 4096)) :
                                                 13'($urandom_range(1, 40)));
         n = $urandom_range(20, 50);
         repeat (n) begin
            if ($urandom_range(0, 9) < 3) send_reload();
            else send_compute();
         end
      end
   endtask

   task automatic test_steady_stream();
      tx_idle_en = 0;
      rx_idle_en = 0;
      set_sizes(13'd9, 13'd6, 13'd23, 13'd17);
      repeat (60) begin
         if ($urandom_range(0, 9) < 3) send_reload();
         else send_compute();
      end
   endtask

   // receiver readiness with random stall bursts
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req > 0) begin
            hold = long_hold_req;
            long_hold_req = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_queue.size() == 0) begin
            report_mismatch("unexpected result, pixel_out", rsp_tdata, -1);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_tdata !== want.pixel) report_mismatch("pixel_out", rsp_tdata, want.pixel);
            if (rsp_tuser !== want.sat) report_mismatch("saturated", rsp_tuser, want.sat);
            if (want.sat) sat_count++;
         end
      end
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      items_sent = 0;
      load_count = 0;
      compute_count = 0;
      sat_count = 0;
      idle_cycles = 0;
      long_hold_req = 0;
      image_fill = 0;
      tx_idle_en = 1;
      rx_idle_en = 1;
      for (int i = 0; i < 4; i++) cfg_reg[i] = 13'd256;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_extreme_sizes();
      test_backpressure();
      test_random_phases(ITEM_TARGET - 60);
      test_steady_stream();

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d loads and %0d interpolated pixels (%0d saturated)",
               load_count, compute_count, sat_count);
      $display("source sizes 1..256, destination sizes 1..4096, zero and oversized values");
      if (error_count == 0 && pixel_queue.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

### files.f
src/bir_pkg.sv
src/bir_div.sv
src/bir_kernel.sv
src/bir_datapath.sv
src/bir_ctrl.sv
src/bicubic_image_resize.sv
sim/testbench.sv
